// ===== hw/rtl/bwcm_pkg.sv =====
`default_nettype none
package bwcm_pkg;

  // one stored window record
  typedef struct packed {
    logic [31:0] height;
    logic [21:0] total;
    logic [21:0] covered;
  } entry_t;

  typedef logic [1:0] health_t;

  localparam health_t HEALTH_INSUFFICIENT = 2'd0;
  localparam health_t HEALTH_LOW_COVERAGE = 2'd1;
  localparam health_t HEALTH_HEALTHY      = 2'd2;

  // configuration register indexes
  localparam logic CFG_COVERAGE_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_WINDOW_WEIGHT  = 1'b1;

  localparam logic [16:0] COVERAGE_THRESHOLD_RST = 17'd52429;
  localparam logic [27:0] MIN_WINDOW_WEIGHT_RST  = 28'd4000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_MUL,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/block_window_coverage_monitor_unit.sv =====
`default_nettype none
// Window coverage monitor. Each input item carries a sequence height and a
// total and covered weight. The block keeps up to WINDOW records with
// consecutive heights in a ring memory: it drops held entries at or above the
// new height, clears the window on a height gap, retires the oldest entry when
// full and appends the new record. Each item yields one result item with the
// window sums and a health state (insufficient, low coverage, healthy), where
// a full window with a total under min_window_weight reports healthy with
// low_activity set. An item is handled in steps: a walk over the ring memory
// reads every held entry below the new height plus the first one at or above
// it, if any (0 to WINDOW entries), through its single registered read port;
// the walk is followed by a write-back state, a multiply state, a result
// state and the idle state in which the next item is taken. The result state
// also waits while the previous result is still stalled in the output
// register. The result sits in that output register, so a new item is taken
// while it waits. The user must write configuration through cfg_wr_en /
// cfg_addr / cfg_wdata only while the block is idle; the block itself does
// not enforce this.
module block_window_coverage_monitor_unit
  import bwcm_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_seq_height,
  input  wire logic [21:0] in_total_weight,
  input  wire logic [21:0] in_covered_weight,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_health,
  output logic             out_low_activity,
  output logic [6:0]       out_tracked_count,
  output logic [27:0]      out_window_total,
  output logic [27:0]      out_window_covered,
  output logic [6:0]       out_rolled_back,
  output logic             out_gap_cleared,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [27:0] cfg_wdata
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] FULL = CW'(WINDOW);

  // ring index of position pos counted from base; both stay below WINDOW
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(pos);
    if (s >= (CW+1)'(WINDOW)) s = s - (CW+1)'(WINDOW);
    return AW'(s);
  endfunction

  // ring storage
  entry_t mem [WINDOW];
  entry_t rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  state_t state_r, state_nxt;

  // configuration
  logic [16:0] thr_r;
  logic [27:0] minw_r;

  // window bookkeeping
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;

  // per-item working registers
  logic [31:0]   h_r, h_nxt;
  logic [21:0]   tw_r, tw_nxt, cw_r, cw_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [31:0]   last_h_r, last_h_nxt;
  logic [21:0]   first_tw_r, first_tw_nxt, first_cw_r, first_cw_nxt;
  logic [27:0]   acc_t_r, acc_t_nxt, acc_c_r, acc_c_nxt;
  logic [27:0]   st_r, st_nxt, sc_r, sc_nxt;
  logic [CW-1:0] rolled_r, rolled_nxt;
  logic          gap_r, gap_nxt, full_r, full_nxt;
  logic [44:0]   prod_r, prod_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  health_t       health_r, health_nxt;
  logic          low_r, low_nxt;
  logic [CW-1:0] o_count_r, o_count_nxt;
  logic [27:0]   o_st_r, o_st_nxt, o_sc_r, o_sc_nxt;
  logic [CW-1:0] o_rolled_r, o_rolled_nxt;
  logic          o_gap_r, o_gap_nxt;

  logic          hit, scan_last, load_out, gap_now;
  logic [CW-1:0] keep_inc;
  logic [44:0]   cov_scaled;
  logic [27:0]   st_less_first, sc_less_first;

  assign in_stall  = (state_r != ST_IDLE);
  assign hit       = (rd_q.height >= h_r);
  assign keep_inc  = keep_r + CW'(1);
  assign scan_last = (keep_inc == count_r);
  assign load_out  = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);
  // heights differ by one: compare in 33 bits so the top height never wraps
  assign gap_now   = (keep_r != '0) &&
                     ({1'b0, last_h_r} + 33'd1 != {1'b0, h_r});
  assign cov_scaled    = {1'b0, sc_r, 16'd0};
  assign st_less_first = acc_t_r - 28'(first_tw_r);
  assign sc_less_first = acc_c_r - 28'(first_cw_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (count_r == '0) ? ST_APPEND : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || scan_last) state_nxt = ST_APPEND;
      end
      ST_APPEND: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    h_nxt        = h_r;
    tw_nxt       = tw_r;
    cw_nxt       = cw_r;
    keep_nxt     = keep_r;
    last_h_nxt   = last_h_r;
    first_tw_nxt = first_tw_r;
    first_cw_nxt = first_cw_r;
    acc_t_nxt    = acc_t_r;
    acc_c_nxt    = acc_c_r;
    st_nxt       = st_r;
    sc_nxt       = sc_r;
    rolled_nxt   = rolled_r;
    gap_nxt      = gap_r;
    full_nxt     = full_r;
    prod_nxt     = prod_r;
    count_nxt    = count_r;
    oldest_nxt   = oldest_r;
    mem_re       = 1'b0;
    mem_raddr    = oldest_r;
    mem_we       = 1'b0;
    mem_waddr    = oldest_r;
    mem_wdata    = '{height: h_r, total: tw_r, covered: cw_r};
    health_nxt   = health_r;
    low_nxt      = low_r;
    o_count_nxt  = o_count_r;
    o_st_nxt     = o_st_r;
    o_sc_nxt     = o_sc_r;
    o_rolled_nxt = o_rolled_r;
    o_gap_nxt    = o_gap_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          h_nxt     = in_seq_height;
          tw_nxt    = in_total_weight;
          cw_nxt    = in_covered_weight;
          keep_nxt  = '0;
          acc_t_nxt = '0;
          acc_c_nxt = '0;
          // fetch the oldest entry for the walk
          mem_re    = 1'b1;
          mem_raddr = oldest_r;
        end
      end
      ST_SCAN: begin
        // rd_q holds the entry at position keep_r
        if (!hit) begin
          keep_nxt   = keep_inc;
          acc_t_nxt  = acc_t_r + 28'(rd_q.total);
          acc_c_nxt  = acc_c_r + 28'(rd_q.covered);
          last_h_nxt = rd_q.height;
          if (keep_r == '0) begin
            first_tw_nxt = rd_q.total;
            first_cw_nxt = rd_q.covered;
          end
          if (!scan_last) begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(oldest_r, keep_inc);
          end
        end
      end
      ST_APPEND: begin
        // sums of at most 64 records of 22 bits fit in 28 bits
        rolled_nxt = count_r - keep_r;
        gap_nxt    = gap_now;
        mem_we     = 1'b1;
        priority if (gap_now) begin
          mem_waddr = oldest_r;
          count_nxt = CW'(1);
          st_nxt    = 28'(tw_r);
          sc_nxt    = 28'(cw_r);
        end else if (keep_r == FULL) begin
          // retire the oldest entry; its slot takes the new record
          mem_waddr  = oldest_r;
          oldest_nxt = slot_of(oldest_r, CW'(1));
          count_nxt  = FULL;
          st_nxt     = st_less_first + 28'(tw_r);
          sc_nxt     = sc_less_first + 28'(cw_r);
        end else begin
          mem_waddr = slot_of(oldest_r, keep_r);
          count_nxt = keep_inc;
          st_nxt    = acc_t_r + 28'(tw_r);
          sc_nxt    = acc_c_r + 28'(cw_r);
        end
        full_nxt = (count_nxt == FULL);
      end
      ST_MUL: begin
        prod_nxt = {28'd0, thr_r} * {17'd0, st_r};
      end
      ST_RESULT: begin
        if (load_out) begin
          priority if (!full_r) begin
            health_nxt = HEALTH_INSUFFICIENT;
            low_nxt    = 1'b0;
          end else if (st_r < minw_r) begin
            health_nxt = HEALTH_HEALTHY;
            low_nxt    = 1'b1;
          end else if (cov_scaled >= prod_r) begin
            health_nxt = HEALTH_HEALTHY;
            low_nxt    = 1'b0;
          end else begin
            health_nxt = HEALTH_LOW_COVERAGE;
            low_nxt    = 1'b0;
          end
          o_count_nxt  = count_r;
          o_st_nxt     = st_r;
          o_sc_nxt     = sc_r;
          o_rolled_nxt = rolled_r;
          o_gap_nxt    = gap_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // ring memory with a registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= COVERAGE_THRESHOLD_RST;
      minw_r <= MIN_WINDOW_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_COVERAGE_THRESHOLD: thr_r  <= cfg_wdata[16:0];
        CFG_MIN_WINDOW_WEIGHT:  minw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    tw_r       <= tw_nxt;
    cw_r       <= cw_nxt;
    keep_r     <= keep_nxt;
    last_h_r   <= last_h_nxt;
    first_tw_r <= first_tw_nxt;
    first_cw_r <= first_cw_nxt;
    acc_t_r    <= acc_t_nxt;
    acc_c_r    <= acc_c_nxt;
    st_r       <= st_nxt;
    sc_r       <= sc_nxt;
    rolled_r   <= rolled_nxt;
    gap_r      <= gap_nxt;
    full_r     <= full_nxt;
    prod_r     <= prod_nxt;
    health_r   <= health_nxt;
    low_r      <= low_nxt;
    o_count_r  <= o_count_nxt;
    o_st_r     <= o_st_nxt;
    o_sc_r     <= o_sc_nxt;
    o_rolled_r <= o_rolled_nxt;
    o_gap_r    <= o_gap_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_health         = health_r;
  assign out_low_activity   = low_r;
  assign out_tracked_count  = 7'(o_count_r);
  assign out_window_total   = o_st_r;
  assign out_window_covered = o_sc_r;
  assign out_rolled_back    = 7'(o_rolled_r);
  assign out_gap_cleared    = o_gap_r;

  // window never holds more than WINDOW entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("window count exceeds depth");

  // walk position stays inside the held entries
  a_scan_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (keep_r < count_r))
    else $error("walk past held entries");

  // an accepted item blocks the input until its result is formed
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice");

  // health is insufficient exactly when the window is not full
  a_health_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_health == HEALTH_INSUFFICIENT) == (o_count_r != FULL)))
    else $error("health disagrees with window fill");

  // low activity only comes with a healthy report
  a_low_healthy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_low_activity) |-> (out_health == HEALTH_HEALTHY))
    else $error("low activity without healthy");

endmodule
`default_nettype wire
